/* src/scg_pkg.sv */
// Shared types, constants and the sine table of the segmented chirp tone generator.
package scg_pkg;

	localparam int SEGMENTS   = 8;
	localparam int SLOT_W     = $clog2(SEGMENTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int SINE_BITS  = 10;
	localparam int ROM_SIZE   = 1 << SINE_BITS;
	localparam int QUARTER    = ROM_SIZE >> 2;
	localparam int PHASE_W    = 32;
	localparam int INC_W      = PHASE_W + 16;
	localparam int SAMPLE_W   = 16;
	localparam int AMP_W      = 16;
	localparam int LEN_W      = 20;
	localparam int INCIN_W    = 31;
	localparam int TOTAL_W    = 24;
	localparam int DIVIDEND_W = INCIN_W + 16;
	localparam int DIVISOR_W  = LEN_W;
	localparam int PROD_W     = SAMPLE_W + AMP_W + 1;

	localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
	localparam longint ROM_PEAK = (64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_START = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		KIND_SINE   = 3'd0,
		KIND_COSINE = 3'd1,
		KIND_CHIRP  = 3'd2,
		KIND_ZERO   = 3'd3,
		KIND_HIGH   = 3'd4,
		KIND_LOW    = 3'd5,
		KIND_BAD6   = 3'd6,
		KIND_BAD7   = 3'd7
	} kind_t;

	typedef enum logic [1:0] {
		ST_SAMPLE   = 2'd0,
		ST_TOO_LONG = 2'd1,
		ST_BAD_KIND = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic {
		REG_SEGMENT_COUNT = 1'b0,
		REG_MAX_TOTAL     = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [AMP_W-1:0]   amp;
		logic [PHASE_W-1:0] phase;
		logic [PHASE_W-1:0] inc;
		logic [INC_W-1:0]   step;
		logic [LEN_W-1:0]   length;
	} seg_entry_t;

	typedef logic [ROM_SIZE-1:0][SAMPLE_W-1:0] rom_t;

	function automatic longint quarter_sine(input int unsigned j);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x = (TWO_PI_Q30 * longint'(j)) >> SINE_BITS;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
		term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
		term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
		if (sum < 0) sum = 0;
		sum = (sum * ROM_PEAK + (64'sd1 <<< 29)) >>> 30;
		if (sum > ROM_PEAK) sum = ROM_PEAK;
		return sum;
	endfunction

	function automatic rom_t build_sine_rom();
		rom_t rom;
		int unsigned q;
		int unsigned r;
		longint v;
		for (int unsigned i = 0; i < ROM_SIZE; i++) begin
			q = i / QUARTER;
			r = i % QUARTER;
			v = (q[0]) ? quarter_sine(QUARTER - r) : quarter_sine(r);
			if (q >= 2) v = -v;
			rom[i] = v[SAMPLE_W-1:0];
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_sine_rom();

endpackage

/* src/scg_if.sv */
// Handshake interfaces for the command and sample channels.
interface scg_req_if;
	import scg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [SLOT_W-1:0]     segment_slot;
	logic [2:0]            kind;
	logic [AMP_W-1:0]      amplitude;
	logic [PHASE_W-1:0]    start_phase;
	logic [INCIN_W-1:0]    start_increment;
	logic [INCIN_W-1:0]    end_increment;
	logic [LEN_W-1:0]      sample_count;
	modport source(output valid, action, segment_slot, kind, amplitude, start_phase,
		start_increment, end_increment, sample_count, input ready);
	modport sink(input valid, action, segment_slot, kind, amplitude, start_phase,
		start_increment, end_increment, sample_count, output ready);
endinterface

interface scg_rsp_if;
	import scg_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic [SLOT_W-1:0]          segment_number;
	logic                       last_of_segment;
	logic                       last_of_waveform;
	logic [1:0]                 status;
	modport source(output valid, sample, segment_number, last_of_segment, last_of_waveform,
		status, input ready);
	modport sink(input valid, sample, segment_number, last_of_segment, last_of_waveform,
		status, output ready);
endinterface

/* src/scg_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* src/scg_div.sv */
// Restoring divider, one quotient bit per cycle, for the chirp step.
module scg_div import scg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVISOR_W:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    rem_sh;
	logic                  fits;

	assign rem_sh = {rem_q[DIVISOR_W-1:0], quo_q[DIVIDEND_W-1]};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

/* src/segmented_chirp_tone_generator_top.sv */
// Segmented chirp tone generator: segment table RAM, sequencer and sample datapath.
//
// Usage: the req channel carries commands (write a table slot, start, tick);
// the rsp channel returns samples and start errors. A transaction moves on
// valid and ready both high. Configuration registers are to be written through
// wr_en / wr_index / wr_data only while the block is idle; the block itself
// does not enforce this, the user is bound by it. Steps per command:
//   write: into the table at once; a chirp of two or more samples first waits
//          in the divide state for the step divider's 47-bit quotient.
//   start: each played slot is read and its length and kind checked; an error
//          then goes through the emit step into the output register, a good
//          start reads and checks slots until the first non-empty segment.
//   tick:  multiply, form and emit steps, then the output register; a sample
//          ending a segment but not the waveform first searches the following slots.
// A finished result sits in an output register; the next command is taken
// while it waits. A new result waits in the emit step while the receiver
// stalls. Reset stops playback and empties the output; the table keeps no
// defined content until written.
module segmented_chirp_tone_generator_top import scg_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic            wr_index,
	input  logic [23:0]     wr_data,
	scg_req_if.sink         req,
	scg_rsp_if.source       rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_SCAN_RD, S_SCAN_CHK, S_START_END,
		S_MUL, S_FORM, S_FIND_RD, S_FIND_CHK, S_EMIT
	} state_t;

	state_t                      state_q;
	logic [CNT_W-1:0]            seg_cnt_q;
	logic [TOTAL_W-1:0]          max_total_q;
	logic                        running_q;
	seg_entry_t                  cur_q;
	logic [SLOT_W-1:0]           cur_seg_q;
	logic [LEN_W-1:0]            sidx_q;
	logic [PHASE_W-1:0]          phase_q;
	logic [INC_W-1:0]            inc_q;
	logic [SLOT_W-1:0]           ptr_q;
	logic [TOTAL_W-1:0]          total_q;
	logic                        bad_q;
	logic [SLOT_W-1:0]           bad_slot_q;
	logic                        from_tick_q;
	logic [SAMPLE_W-1:0]         rom_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic                        lastseg_q;
	seg_entry_t                  wr_entry_q;
	logic [SLOT_W-1:0]           wr_slot_q;
	logic                        div_neg_q;
	logic [SAMPLE_W-1:0]         res_sample_q;
	logic [SLOT_W-1:0]           res_seg_q;
	logic                        res_ls_q;
	logic                        res_lw_q;
	logic [1:0]                  res_status_q;
	logic                        out_valid_q;
	logic [SAMPLE_W-1:0]         out_sample_q;
	logic [SLOT_W-1:0]           out_seg_q;
	logic                        out_ls_q;
	logic                        out_lw_q;
	logic [1:0]                  out_status_q;

	logic [CNT_W-1:0]            used_n;
	logic                        accept;
	seg_entry_t                  new_entry;
	logic                        chirp_div;
	logic signed [PHASE_W-1:0]   diff;
	logic [INCIN_W-1:0]          diff_mag;
	logic                        div_done;
	logic [DIVIDEND_W-1:0]       div_quo;
	logic                        ram_we;
	logic [SLOT_W-1:0]           ram_waddr;
	seg_entry_t                  ram_wdata;
	seg_entry_t                  ram_rdata;
	logic [SINE_BITS-1:0]        rom_idx;
	logic                        tick_last;
	logic [PROD_W-1:0]           prod_mag;
	logic [SAMPLE_W-1:0]         scaled_mag;
	logic [SAMPLE_W-1:0]         scaled_val;
	logic [SAMPLE_W-1:0]         form_val;
	logic                        emit_go;

	assign used_n = (seg_cnt_q > CNT_W'(SEGMENTS)) ? CNT_W'(SEGMENTS) : seg_cnt_q;
	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;

	// Table entry built from the command fields; the chirp step is filled in later.
	always_comb begin
		new_entry.kind   = req.kind;
		new_entry.amp    = req.amplitude;
		new_entry.phase  = req.start_phase;
		new_entry.inc    = {1'b0, req.start_increment};
		new_entry.step   = '0;
		new_entry.length = req.sample_count;
	end

	assign chirp_div = (req.kind == KIND_CHIRP) && (req.sample_count > LEN_W'(1));
	assign diff = $signed({1'b0, req.end_increment}) - $signed({1'b0, req.start_increment});
	assign diff_mag = diff[PHASE_W-1] ? INCIN_W'(-diff) : diff[INCIN_W-1:0];

	scg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && (req.action == ACT_WRITE) && chirp_div),
		.dividend ({diff_mag, 16'b0}),
		.divisor  (req.sample_count - LEN_W'(1)),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = req.segment_slot;
		ram_wdata = new_entry;
		if (state_q == S_IDLE && accept && req.action == ACT_WRITE && !chirp_div) begin
			ram_we = 1'b1;
		end else if (state_q == S_DIV && div_done) begin
			ram_we         = 1'b1;
			ram_waddr      = wr_slot_q;
			ram_wdata      = wr_entry_q;
			ram_wdata.step = div_neg_q ? -{1'b0, div_quo} : {1'b0, div_quo};
		end
	end

	scg_ram #(.WIDTH($bits(seg_entry_t)), .DEPTH(SEGMENTS)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign rom_idx = phase_q[PHASE_W-1 -: SINE_BITS]
		+ ((cur_q.kind == KIND_COSINE) ? SINE_BITS'(QUARTER) : SINE_BITS'(0));
	assign tick_last = ({1'b0, sidx_q} + 1'b1) >= {1'b0, cur_q.length};

	// Product shifted down with truncation toward zero.
	assign prod_mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign scaled_mag = prod_mag[AMP_W +: SAMPLE_W];
	assign scaled_val = prod_q[PROD_W-1] ? -scaled_mag : scaled_mag;

	always_comb begin
		case (cur_q.kind)
			KIND_SINE, KIND_CHIRP, KIND_COSINE: form_val = scaled_val;
			KIND_HIGH: form_val = SAMPLE_W'(cur_q.amp >> 1);
			KIND_LOW:  form_val = -SAMPLE_W'(cur_q.amp >> 1);
			default:   form_val = '0;
		endcase
	end

	assign emit_go = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seg_cnt_q   <= '0;
			max_total_q <= '1;
			running_q   <= 1'b0;
			cur_seg_q   <= '0;
			sidx_q      <= '0;
			phase_q     <= '0;
			inc_q       <= '0;
			ptr_q       <= '0;
			from_tick_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.action)
							ACT_WRITE: begin
								running_q  <= 1'b0;
								wr_entry_q <= new_entry;
								wr_slot_q  <= req.segment_slot;
								div_neg_q  <= diff[PHASE_W-1];
								if (chirp_div) state_q <= S_DIV;
							end
							ACT_START: begin
								running_q   <= 1'b0;
								total_q     <= '0;
								bad_q       <= 1'b0;
								ptr_q       <= '0;
								from_tick_q <= 1'b0;
								if (used_n != '0) state_q <= S_SCAN_RD;
							end
							ACT_TICK: begin
								if (running_q) begin
									rom_q     <= SINE_ROM[rom_idx];
									phase_q   <= phase_q + inc_q[INC_W-1 -: PHASE_W];
									inc_q     <= inc_q + cur_q.step;
									lastseg_q <= tick_last;
									if (!tick_last) sidx_q <= sidx_q + 1'b1;
									res_seg_q <= cur_seg_q;
									state_q   <= S_MUL;
								end
							end
							default: ;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_IDLE;
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					total_q <= total_q + TOTAL_W'(ram_rdata.length);
					if (ram_rdata.kind > KIND_LOW && !bad_q) begin
						bad_q      <= 1'b1;
						bad_slot_q <= ptr_q;
					end
					if (({1'b0, ptr_q} + 1'b1) >= used_n) begin
						state_q <= S_START_END;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_START_END: begin
					res_sample_q <= '0;
					res_ls_q     <= 1'b0;
					res_lw_q     <= 1'b0;
					if (total_q > max_total_q) begin
						res_status_q <= ST_TOO_LONG;
						res_seg_q    <= '0;
						state_q      <= S_EMIT;
					end else if (bad_q) begin
						res_status_q <= ST_BAD_KIND;
						res_seg_q    <= bad_slot_q;
						state_q      <= S_EMIT;
					end else begin
						res_seg_q <= '0;
						ptr_q     <= '0;
						state_q   <= S_FIND_RD;
					end
				end
				S_MUL: begin
					prod_q  <= $signed(rom_q) * $signed({1'b0, cur_q.amp});
					state_q <= S_FORM;
				end
				S_FORM: begin
					res_sample_q <= form_val;
					res_ls_q     <= lastseg_q;
					res_status_q <= ST_SAMPLE;
					if (lastseg_q) begin
						from_tick_q <= 1'b1;
						if (({1'b0, cur_seg_q} + 1'b1) >= used_n) begin
							running_q <= 1'b0;
							res_lw_q  <= 1'b1;
							state_q   <= S_EMIT;
						end else begin
							res_lw_q <= 1'b0;
							ptr_q    <= cur_seg_q + 1'b1;
							state_q  <= S_FIND_RD;
						end
					end else begin
						res_lw_q <= 1'b0;
						state_q  <= S_EMIT;
					end
				end
				S_FIND_RD: state_q <= S_FIND_CHK;
				S_FIND_CHK: begin
					if (ram_rdata.length != '0) begin
						// Enter the segment; a chirp starts one increment ahead.
						cur_q     <= ram_rdata;
						cur_seg_q <= ptr_q;
						sidx_q    <= '0;
						phase_q   <= ram_rdata.phase
							+ ((ram_rdata.kind == KIND_CHIRP) ? ram_rdata.inc : '0);
						inc_q     <= {ram_rdata.inc, 16'b0};
						running_q <= 1'b1;
						state_q   <= from_tick_q ? S_EMIT : S_IDLE;
					end else if (({1'b0, ptr_q} + 1'b1) >= used_n) begin
						running_q <= 1'b0;
						res_lw_q  <= 1'b1;
						state_q   <= from_tick_q ? S_EMIT : S_IDLE;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= S_FIND_RD;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q  <= 1'b1;
						out_sample_q <= res_sample_q;
						out_seg_q    <= res_seg_q;
						out_ls_q     <= res_ls_q;
						out_lw_q     <= res_lw_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (wr_en) begin
				if (wr_index == REG_SEGMENT_COUNT) begin
					seg_cnt_q <= wr_data[CNT_W-1:0];
					running_q <= 1'b0;
				end else begin
					max_total_q <= wr_data[TOTAL_W-1:0];
				end
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.sample           = $signed(out_sample_q);
	assign rsp.segment_number   = out_seg_q;
	assign rsp.last_of_segment  = out_ls_q;
	assign rsp.last_of_waveform = out_lw_q;
	assign rsp.status           = out_status_q;

endmodule

/* src/scg_checker.sv */
// Port-level checks for the segmented chirp tone generator, bound to the top level.
module scg_checker import scg_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic [1:0]          req_action,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [SAMPLE_W-1:0] rsp_sample,
	input logic                rsp_ls,
	input logic                rsp_lw,
	input logic [1:0]          rsp_status
);

	// A stalled result keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_status))
		else $error("result changed while stalled");

	// The end of the waveform is always also the end of a segment.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_lw |-> rsp_ls)
		else $error("waveform end without segment end");

	// Start errors carry no sample and no end flags.
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_SAMPLE |-> rsp_sample == '0 && !rsp_ls && !rsp_lw)
		else $error("error result with sample data");

	// A table write never produces a result.
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_action == ACT_WRITE && !rsp_valid |=> !rsp_valid)
		else $error("result after a table write");

endmodule

bind segmented_chirp_tone_generator_top scg_checker u_scg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.req_action (req.action),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_sample (rsp.sample),
	.rsp_ls     (rsp.last_of_segment),
	.rsp_lw     (rsp.last_of_waveform),
	.rsp_status (rsp.status)
);
